FILE: rtl/nst_pkg.sv
// nst_pkg: types and codes shared by the name set table.
// Holds the request and response payload structs, the operation and status
// codes and the sequencer state type. Depends on nothing.
package nst_pkg;

   // Default table depth
   localparam int MAX_ENTRIES_DEFAULT = 16;

   // Key width: eight zero-padded bytes
   localparam int KEY_W = 64;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_DELETE = 2'd1,
      OP_LIST   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      STATUS_ADDED     = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_DELETED   = 3'd3,
      STATUS_NOT_FOUND = 3'd4,
      STATUS_EMPTY     = 3'd5,
      STATUS_LISTED    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE_RD,
      S_MOVE_WR,
      S_REPLY,
      S_LIST_RD,
      S_LIST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]       operation;
      logic [KEY_W-1:0] file_key;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [KEY_W-1:0] entry_key;
      logic             last_result;
   } rsp_type;

endpackage

FILE: rtl/name_set_table.sv
// name_set_table: bounded set of unique 64-bit names with a count.
// Uses nst_pkg for payload structs, codes and the sequencer state type.
// Entries live in a single-port-write, registered-read array in this module.
//
//   channel   ports                          direction  payload
//   request   req_valid req_stall req_data   in         operation, file_key
//   response  rsp_valid rsp_stall rsp_data   out        status, entry_key, last_result
//
// Steps: create scans the entries and then replies; delete scans, then reads the last
// entry and writes it into the freed slot, then replies. One 64-bit comparator walks
// the entries behind the registered read port. List reads each entry, then sends it.
// Reset clears the sequencer, the count and the response valid; the entry array
// is not cleared since only entries below the count are read.
// req_stall is high while a request is in progress; rsp_stall holds the response.
module name_set_table #(
   parameter int MAX_ENTRIES = nst_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nst_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   nst_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [nst_pkg::KEY_W-1:0] key_ff, key_in;
   logic [1:0]         op_ff, op_in;
   logic [2:0]         reply_ff, reply_in;
   logic [nst_pkg::KEY_W-1:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   nst_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [nst_pkg::KEY_W-1:0] mem [MAX_ENTRIES];
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [nst_pkg::KEY_W-1:0] wr_data;
   logic               rsp_load;
   nst_pkg::rsp_type   rsp_next;

   logic accept;
   logic out_free;
   logic hit;
   logic miss_done;
   logic is_full;
   logic list_last;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (count_ff == CNT_W'(MAX_ENTRIES));
   assign list_last = ((idx_ff + CNT_W'(1)) == count_ff);

   // Shared comparator: check the entry read in the previous scan cycle
   assign hit       = (state_ff == nst_pkg::S_SCAN) && pend_ff && (rd_data_ff == key_ff);
   assign miss_done = (state_ff == nst_pkg::S_SCAN) && (idx_ff >= count_ff) && !hit;

   assign req_stall = (state_ff != nst_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nst_pkg::S_IDLE: begin
            if (accept) begin
               priority if (req_data.operation == nst_pkg::OP_CREATE ||
                            req_data.operation == nst_pkg::OP_DELETE) begin
                  state_in = nst_pkg::S_SCAN;
               end else if (req_data.operation == nst_pkg::OP_LIST) begin
                  state_in = (count_ff == '0) ? nst_pkg::S_REPLY : nst_pkg::S_LIST_RD;
               end else begin
                  state_in = nst_pkg::S_IDLE;
               end
            end
         end
         nst_pkg::S_SCAN: begin
            if (hit && op_ff == nst_pkg::OP_DELETE) begin
               state_in = nst_pkg::S_MOVE_RD;
            end else if (hit || miss_done) begin
               state_in = nst_pkg::S_REPLY;
            end
         end
         nst_pkg::S_MOVE_RD:  state_in = nst_pkg::S_MOVE_WR;
         nst_pkg::S_MOVE_WR:  state_in = nst_pkg::S_REPLY;
         nst_pkg::S_REPLY: begin
            if (out_free) state_in = nst_pkg::S_IDLE;
         end
         nst_pkg::S_LIST_RD:  state_in = nst_pkg::S_LIST_OUT;
         nst_pkg::S_LIST_OUT: begin
            if (out_free) begin
               state_in = list_last ? nst_pkg::S_IDLE : nst_pkg::S_LIST_RD;
            end
         end
         default:             state_in = nst_pkg::S_IDLE;
      endcase
   end

   // Datapath control per state
   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      slot_in     = slot_ff;
      key_in      = key_ff;
      op_in       = op_ff;
      reply_in    = reply_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = key_ff;
      rsp_load    = 1'b0;
      rsp_next    = '0;
      unique case (state_ff)
         nst_pkg::S_IDLE: begin
            // Capture the request and restart the walk
            if (accept) begin
               key_in   = req_data.file_key;
               op_in    = req_data.operation;
               idx_in   = '0;
               reply_in = nst_pkg::STATUS_EMPTY;
            end
         end
         nst_pkg::S_SCAN: begin
            // Issue the next read while comparing the previous one
            if (idx_ff < count_ff) begin
               rd_addr     = idx_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
            end
            if (hit) begin
               slot_in  = pend_idx_ff;
               reply_in = (op_ff == nst_pkg::OP_CREATE) ? nst_pkg::STATUS_DUPLICATE
                                                        : nst_pkg::STATUS_DELETED;
            end else if (miss_done) begin
               if (op_ff == nst_pkg::OP_DELETE) begin
                  reply_in = nst_pkg::STATUS_NOT_FOUND;
               end else if (is_full) begin
                  reply_in = nst_pkg::STATUS_FULL;
               end else begin
                  // Append at the tail
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = key_ff;
                  count_in = count_ff + CNT_W'(1);
                  reply_in = nst_pkg::STATUS_ADDED;
               end
            end
         end
         nst_pkg::S_MOVE_RD: begin
            // Fetch the last entry
            rd_addr = IDX_W'(count_ff - CNT_W'(1));
         end
         nst_pkg::S_MOVE_WR: begin
            // Move the last entry into the freed slot
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data_ff;
            count_in = count_ff - CNT_W'(1);
         end
         nst_pkg::S_REPLY: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_next.status      = reply_ff;
               rsp_next.entry_key   = '0;
               rsp_next.last_result = 1'b1;
            end
         end
         nst_pkg::S_LIST_RD: begin
            rd_addr = idx_ff[IDX_W-1:0];
         end
         nst_pkg::S_LIST_OUT: begin
            // Hold the read address so the entry stays on the read port
            rd_addr = idx_ff[IDX_W-1:0];
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_next.status      = nst_pkg::STATUS_LISTED;
               rsp_next.entry_key   = rd_data_ff;
               rsp_next.last_result = list_last;
               idx_in               = idx_ff + CNT_W'(1);
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nst_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      key_ff      <= key_in;
      op_ff       <= op_in;
      reply_ff    <= reply_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Entry array: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Count stays within the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   // Count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ##1 (count_ff == $past(count_ff) ||
           count_ff == $past(count_ff) + CNT_W'(1) ||
           count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count jumped");

   // Only listed entries carry a key
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != nst_pkg::STATUS_LISTED) |-> (rsp_data.entry_key == '0))
      else $error("key on a non-list response");

   // A request without a list always ends in a single final response
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_result) |-> (rsp_data.status == nst_pkg::STATUS_LISTED))
      else $error("non-final flag on a single response");

endmodule

FILE: tb/sv/name_set_table_checker.sv
`timescale 1ns / 1ps
// name_set_table_checker: watches the request and response channels of the name
// set table, keeps its own copy of the table and checks every response in order.
// Depends on nst_pkg for the payload structs and the operation and status codes.
module name_set_table_checker #(
   parameter int MAX_ENTRIES = nst_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  nst_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  nst_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               outstanding,
   output int               request_total,
   output int               response_total,
   output int               peak_fill,
   output logic [7:0]       statuses_seen
);

   localparam int REPORT_LIMIT = 10;

   logic [nst_pkg::KEY_W-1:0] shadow_names [MAX_ENTRIES];
   int                        shadow_count;
   nst_pkg::rsp_type          expected_rsp_q [$];
   int                        mismatches;
   int                        requests_seen;
   int                        responses_seen;
   int                        fill_high;
   logic [7:0]                status_mask = '0;

   function automatic nst_pkg::rsp_type make_rsp(nst_pkg::status_type status,
                                                 logic [nst_pkg::KEY_W-1:0] key,
                                                 logic last);
      nst_pkg::rsp_type r;
      r.status      = status;
      r.entry_key   = key;
      r.last_result = last;
      return r;
   endfunction

   // Return the slot that holds key, or -1 when it is not in the table
   function automatic int find_name(logic [nst_pkg::KEY_W-1:0] key);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_names[i] == key) return i;
      end
      return -1;
   endfunction

   // Apply one request to the table copy and queue the responses it causes
   function automatic void predict_request(nst_pkg::req_type req);
      int slot;
      slot = find_name(req.file_key);
      case (req.operation)
         nst_pkg::OP_CREATE: begin
            if (slot >= 0) begin
               expected_rsp_q.push_back(make_rsp(nst_pkg::STATUS_DUPLICATE, '0, 1'b1));
            end else if (shadow_count >= MAX_ENTRIES) begin
               expected_rsp_q.push_back(make_rsp(nst_pkg::STATUS_FULL, '0, 1'b1));
            end else begin
               shadow_names[shadow_count] = req.file_key;
               shadow_count++;
               expected_rsp_q.push_back(make_rsp(nst_pkg::STATUS_ADDED, '0, 1'b1));
            end
         end
         nst_pkg::OP_DELETE: begin
            if (slot >= 0) begin
               // move the last entry into the freed slot
               shadow_names[slot] = shadow_names[shadow_count - 1];
               shadow_count--;
               expected_rsp_q.push_back(make_rsp(nst_pkg::STATUS_DELETED, '0, 1'b1));
            end else begin
               expected_rsp_q.push_back(make_rsp(nst_pkg::STATUS_NOT_FOUND, '0, 1'b1));
            end
         end
         nst_pkg::OP_LIST: begin
            if (shadow_count == 0) begin
               expected_rsp_q.push_back(make_rsp(nst_pkg::STATUS_EMPTY, '0, 1'b1));
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  expected_rsp_q.push_back(make_rsp(nst_pkg::STATUS_LISTED,
                                                    shadow_names[i],
                                                    i == shadow_count - 1));
               end
            end
         end
         default: begin
            // unused code: no response, no change
         end
      endcase
      if (shadow_count > fill_high) fill_high = shadow_count;
   endfunction

   // Compare one accepted response with the oldest expected one
   function automatic void check_response(nst_pkg::rsp_type got);
      nst_pkg::rsp_type want;
      responses_seen++;
      status_mask[got.status] = 1'b1;
      if (expected_rsp_q.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("[%0t] unexpected response: status %0d key %h last %b",
                     $realtime, got.status, got.entry_key, got.last_result);
         return;
      end
      want = expected_rsp_q.pop_front();
      if (got.status != want.status || got.entry_key != want.entry_key ||
          got.last_result != want.last_result) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] response mismatch:", $realtime);
            $display("   expected status %0d key %h last %b",
                     want.status, want.entry_key, want.last_result);
            $display("   actual   status %0d key %h last %b",
                     got.status, got.entry_key, got.last_result);
         end
      end
   endfunction

   // Sample both channels at the edge; publish counters for the top
   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_response(rsp_data);
         if (req_valid && !req_stall) begin
            requests_seen++;
            predict_request(req_data);
         end
      end
      fail_count     <= mismatches;
      outstanding    <= expected_rsp_q.size();
      request_total  <= requests_seen;
      response_total <= responses_seen;
      peak_fill      <= fill_high;
      statuses_seen  <= status_mask;
   end

endmodule

FILE: tb/sv/name_set_table_tb.sv
`timescale 1ns / 1ps
// name_set_table_tb: drives requests into the name set table under random idling
// and gives the verdict. Depends on nst_pkg, name_set_table and the checker.
module name_set_table_tb;

   localparam int         QUIET_LIMIT = 5000;
   localparam int         TAIL_CYCLES = 60;
   localparam int         POOL_SIZE   = 24;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   nst_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   nst_pkg::rsp_type          rsp_data;

   int                        fail_count;
   int                        outstanding;
   int                        request_total;
   int                        response_total;
   int                        peak_fill;
   logic [7:0]                statuses_seen;

   int unsigned               send_idle_pct;
   int unsigned               recv_idle_pct;
   logic [nst_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
   bit                        stimulus_done;

   name_set_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   name_set_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .request_total  (request_total),
      .response_total (response_total),
      .peak_fill      (peak_fill),
      .statuses_seen  (statuses_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Idle at random, then hold the request until it is taken
   task automatic send_request(input logic [1:0] op, input logic [nst_pkg::KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {op, key};
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every expected response has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [nst_pkg::KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Random requests, mostly on a small pool of names so that hits are common
   task automatic run_random(input int unsigned items);
      int unsigned               sent;
      int unsigned               pick;
      logic [1:0]                op;
      logic [nst_pkg::KEY_W-1:0] key;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 50) op = nst_pkg::OP_CREATE;
         else if (pick < 80) op = nst_pkg::OP_DELETE;
         else if (pick < 95) op = nst_pkg::OP_LIST;
         else op = OP_UNUSED;
         if ($urandom_range(99) < 80) key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else key = random_key();
         send_request(op, key);
         if (op != OP_UNUSED) sent++;
      end
   endtask

   task automatic run_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty table, zero and all-ones names, duplicate, unused code
      send_request(nst_pkg::OP_LIST, random_key());
      send_request(nst_pkg::OP_DELETE, key_pool[0]);
      send_request(nst_pkg::OP_CREATE, key_pool[0]);
      send_request(nst_pkg::OP_CREATE, key_pool[1]);
      send_request(nst_pkg::OP_CREATE, key_pool[0]);
      send_request(nst_pkg::OP_DELETE, key_pool[0]);
      send_request(nst_pkg::OP_DELETE, key_pool[0]);
      send_request(OP_UNUSED, random_key());
      send_request(nst_pkg::OP_LIST, random_key());

      // Fill to capacity, then full, duplicate when full, full list, deletes
      for (int i = 2; i < 17; i++) send_request(nst_pkg::OP_CREATE, key_pool[i]);
      send_request(nst_pkg::OP_CREATE, key_pool[17]);
      send_request(nst_pkg::OP_CREATE, key_pool[1]);
      send_request(nst_pkg::OP_LIST, random_key());
      send_request(nst_pkg::OP_DELETE, key_pool[9]);
      send_request(nst_pkg::OP_DELETE, key_pool[16]);
      wait_drained();

      run_random(40);
      wait_drained();

      send_idle_pct = 58;
      recv_idle_pct = 9;
      run_random(40);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(40);
      wait_drained();

      // Let an ignored request or any stray response show up
      repeat (TAIL_CYCLES) @(posedge clock);
      stimulus_done = 1'b1;
   endtask

   // Return once no request or response has moved for too long
   task automatic watch_progress();
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      send_idle_pct = 9;
      recv_idle_pct = 58;
      stimulus_done = 1'b0;
      key_pool[0]   = '0;
      key_pool[1]   = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = random_key();

      fork
         run_stimulus();
         watch_progress();
      join_any

      $display("Ran %0d requests with %0d responses checked in order.",
               request_total, response_total);
      $display("Table filled up to %0d entries; status codes seen (bit per code): %b.",
               peak_fill, statuses_seen);
      if (!stimulus_done) begin
         $display("No handshake for %0d cycles, %0d responses still expected.",
                  QUIET_LIMIT, outstanding);
         $display("simulation failed");
      end else if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/nst_pkg.sv
rtl/name_set_table.sv
tb/sv/name_set_table_checker.sv
tb/sv/name_set_table_tb.sv
